>>> hw/rtl/gsw_pkg.sv
// Shared types, constants and GF(2) matrix helpers for the Gold sequence word generator.
// Used by the interfaces and every module of the block; depends on nothing.
package gsw_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned SeedW    = 31;
  localparam int unsigned NcOffset = 1600;

  typedef enum logic {
    CmdContinue,
    CmdRestart
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic [WordW-1:0]   x1_word;
    logic               last_word;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  typedef logic [WordW-1:0][WordW-1:0] gf2_mat_t;

  // Row b holds the seed bits whose XOR gives window bit b after the Nc jump.
  // Masks of x2(n) over the seed bits are tracked in a sliding set of 31.
  function automatic gf2_mat_t jump_rows();
    logic [SeedW-1:0][SeedW-1:0] hist;
    logic [SeedW-1:0]            nm;
    gf2_mat_t                    rows;
    rows = '0;
    for (int i = 0; i < SeedW; i++) begin
      hist[i] = SeedW'(1) << i;
    end
    for (int n = SeedW; n < NcOffset + WordW; n++) begin
      nm = hist[0] ^ hist[1] ^ hist[2] ^ hist[3];
      if (n >= NcOffset) begin
        rows[WordW-1-(n-NcOffset)] = {1'b0, nm};
      end
      hist = {nm, hist[SeedW-1:1]};
    end
    return rows;
  endfunction

  // Row b holds the old window bits whose XOR gives new window bit b after 32 steps.
  function automatic gf2_mat_t adv_rows();
    logic [2*WordW-1:0][WordW-1:0] m;
    gf2_mat_t                      rows;
    for (int k = 0; k < WordW; k++) begin
      m[k] = WordW'(1) << (WordW - 1 - k);
    end
    for (int n = WordW; n < 2 * WordW; n++) begin
      m[n] = m[n-SeedW] ^ m[n-SeedW+1] ^ m[n-SeedW+2] ^ m[n-SeedW+3];
    end
    for (int j = 0; j < WordW; j++) begin
      rows[WordW-1-j] = m[WordW+j];
    end
    return rows;
  endfunction

  localparam gf2_mat_t JumpRows = jump_rows();
  localparam gf2_mat_t AdvRows  = adv_rows();

  // Matrix times vector over GF(2); each output bit is an independent XOR tree.
  function automatic logic [WordW-1:0] gf2_apply(gf2_mat_t rows, logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int b = 0; b < WordW; b++) begin
      r[b] = ^(rows[b] & v);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/gsw_if.sv
// Valid/ready channel interfaces for the Gold sequence word generator.
// Depends on gsw_pkg for the field widths.
interface gsw_in_if import gsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] x1_word;
  logic             first;
  logic             last_word;

  modport source (output valid, x1_word, first, last_word, input ready);
  modport sink   (input valid, x1_word, first, last_word, output ready);
endinterface

interface gsw_out_if import gsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] c_word;
  logic             last;

  modport source (output valid, c_word, last, input ready);
  modport sink   (input valid, c_word, last, output ready);
endinterface

>>> hw/rtl/gsw_front.sv
// Front end: holds the jumped seed window and turns accepted items into queue commands.
// Depends on gsw_pkg and gsw_in_if.
module gsw_front import gsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SeedW-1:0] cfg_wdata_i,
  gsw_in_if.sink           in_i,
  input  logic             q_full_i,
  output q_wr_t            q_wr_o,
  output logic [WordW-1:0] seed_win_o
);

  logic [WordW-1:0] seed_win_d, seed_win_q;

  // The Nc jump is linear in the seed, so it is applied once when the seed is written.
  always_comb begin
    seed_win_d = seed_win_q;
    if (cfg_we_i) begin
      seed_win_d = gf2_apply(JumpRows, {1'b0, cfg_wdata_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_win_q <= '0;
    end else begin
      seed_win_q <= seed_win_d;
    end
  end

  assign in_i.ready = !q_full_i;

  always_comb begin
    q_wr_o.push          = in_i.valid && !q_full_i;
    q_wr_o.cmd.op        = in_i.first ? CmdRestart : CmdContinue;
    q_wr_o.cmd.x1_word   = in_i.x1_word;
    q_wr_o.cmd.last_word = in_i.last_word;
  end

  assign seed_win_o = seed_win_q;

endmodule

>>> hw/rtl/gsw_queue.sv
// Small command queue between the front and back ends.
// Depends on gsw_pkg.
module gsw_queue import gsw_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output q_rd_t q_rd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] count_d, count_q;
  logic            push, pop, empty;

  assign full_o = (count_q == CntW'(Depth));
  assign empty  = (count_q == '0);
  assign push   = q_wr_i.push && !full_o;
  assign pop    = pop_i && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= q_wr_i.cmd;
    end
  end

  assign q_rd_o.valid = !empty;
  assign q_rd_o.cmd   = mem_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_wr_i.push |-> !full_o)
    else $error("Front end pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty)
    else $error("Back end popped an empty queue.");
`endif

endmodule

>>> hw/rtl/gsw_back.sv
// Back end: keeps the x2 window, forms the sequence word and holds it in the output register.
// Depends on gsw_pkg and gsw_out_if.
module gsw_back import gsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_rd_t            q_rd_i,
  output logic             q_pop_o,
  input  logic [WordW-1:0] seed_win_i,
  gsw_out_if.source        out_o
);

  logic [WordW-1:0] window_d, window_q;
  logic [WordW-1:0] c_word_d, c_word_q;
  logic             last_d, last_q;
  logic             out_valid_d, out_valid_q;
  logic [WordW-1:0] cur_win;
  logic             pop;

  // The output register takes a new word when it is empty or being drained.
  assign pop     = q_rd_i.valid && (!out_valid_q || out_o.ready);
  assign q_pop_o = pop;

  always_comb begin
    unique case (q_rd_i.cmd.op)
      CmdRestart:  cur_win = seed_win_i;
      CmdContinue: cur_win = window_q;
      default:     cur_win = window_q;
    endcase
  end

  always_comb begin
    window_d    = window_q;
    c_word_d    = c_word_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (pop) begin
      window_d    = gf2_apply(AdvRows, cur_win);
      c_word_d    = cur_win ^ q_rd_i.cmd.x1_word;
      last_d      = q_rd_i.cmd.last_word;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_word_q <= c_word_d;
    last_q   <= last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.c_word = c_word_q;
  assign out_o.last   = last_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) (out_valid_q && !out_o.ready) |-> !pop)
    else $error("Command popped while the output word was stalled.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !pop |=> $stable(window_q))
    else $error("Sequence window moved without a command.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> out_valid_q)
    else $error("Popped command produced no output word.");
`endif

endmodule

>>> hw/rtl/gold_sequence_word_generator.sv
// Top level of the Gold scrambling sequence word generator.
// Depends on gsw_pkg, gsw_if, gsw_front, gsw_queue and gsw_back.
//
// Usage:
//   in_i carries one item per word: x1_word (the caller's x1 bits, earliest bit in the MSB),
//   first and last_word. out_o returns one item per input item: c_word, the scrambling
//   bits with the earliest bit in the MSB, and last, a copy of last_word.
//   An item with first set restarts x2 from the seed, already jumped 1600 steps ahead.
//   The user writes the seed through cfg_we_i / cfg_wdata_i only while the block is idle;
//   this is not enforced. The 1600-step jump is applied at that write, not at a restart.
// Timing:
//   An accepted item is written into the queue, then popped into the output register, whose
//   word drives out_o; a stalled out_o can hold an item in the queue between the two.
//   While out_o is ready, one item is accepted and one result delivered in every cycle; the
//   32-step x2 advance is a single XOR network between the window register and itself.
// Reset and stall:
//   Reset empties the queue, drops the output word, and clears the seed and the window.
//   When out_o stalls, the output register holds its word and the queue fills; in_i.ready
//   falls only when the queue is full.
module gold_sequence_word_generator import gsw_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SeedW-1:0] cfg_wdata_i,
  gsw_in_if.sink           in_i,
  gsw_out_if.source        out_o
);

  q_wr_t            q_wr;
  q_rd_t            q_rd;
  logic             q_full;
  logic             q_pop;
  logic [WordW-1:0] seed_win;

  gsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .seed_win_o  (seed_win)
  );

  gsw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  gsw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_rd_i     (q_rd),
    .q_pop_o    (q_pop),
    .seed_win_i (seed_win),
    .out_o      (out_o)
  );

endmodule
